### rtl/hdu_pkg.sv
`timescale 1ns / 1ps

package hdu_pkg;

  // Fixed formats
  localparam int AngleFrac   = 16;
  localparam int CordicN     = 24;
  localparam int LatW        = 24;
  localparam int LonW        = 25;
  localparam int DistW       = 23;
  localparam int HalfW       = 28;   // degrees with AngleFrac+1 fraction bits
  localparam int RadShift    = AngleFrac + 1 + 8;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 25;

  localparam logic signed [33:0] Turn    = 34'sd360 <<< (AngleFrac + 1);
  localparam logic signed [33:0] Half    = Turn >>> 1;
  localparam logic signed [33:0] Quarter = Turn >>> 2;

  localparam logic [32:0] RadPerDeg = 33'd4797524517;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam logic [22:0] DistScale = 23'd3261952;

  localparam logic [CfgIdxW-1:0] RegRefLat = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRefLon = 1'b1;

  // Arctangent table in Q30, truncated
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] t;
    begin
      case (i)
        0: t = 34'sd843314856;
        1: t = 34'sd497837829;
        2: t = 34'sd263043836;
        3: t = 34'sd133525158;
        4: t = 34'sd67021687;
        5: t = 34'sd33543515;
        6: t = 34'sd16775850;
        7: t = 34'sd8388437;
        8: t = 34'sd4194282;
        9: t = 34'sd2097149;
        default: t = (i < 30) ? ((34'sd1 <<< (30 - i)) - 34'sd1) : 34'sd0;
      endcase
      return t;
    end
  endfunction

endpackage

### rtl/hdu_if.sv
`timescale 1ns / 1ps

interface hdu_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hdu_pkg::LatW-1:0]      point_latitude;
  logic signed [hdu_pkg::LonW-1:0]      point_longitude;
  modport source (output valid, point_latitude, point_longitude, input ready);
  modport sink   (input valid, point_latitude, point_longitude, output ready);
endinterface

interface hdu_dist_if;
  logic                          valid;
  logic                          ready;
  logic [hdu_pkg::DistW-1:0]     distance_km;
  modport source (output valid, distance_km, input ready);
  modport sink   (input valid, distance_km, output ready);
endinterface

interface hdu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hdu_pkg::CfgIdxW-1:0]       index;
  logic [hdu_pkg::CfgDataW-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/hdu_sincos.sv
`timescale 1ns / 1ps

// Pipelined sine/cosine: angle reduce, radian conversion, then one CORDIC
// rotation per stage; all registers advance on en.
module hdu_sincos (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [hdu_pkg::HalfW-1:0]  angle,
  output logic signed [33:0]                sin_q30,
  output logic signed [33:0]                cos_q30
);

  localparam int N = hdu_pkg::CordicN;

  logic signed [33:0] mag_r;
  logic               neg_r, flip_r, neg2_r, flip2_r;
  logic [66:0]        prod_r;
  logic signed [33:0] x_r [0:N];
  logic signed [33:0] y_r [0:N];
  logic signed [33:0] z_r [0:N];
  logic               fl_r [0:N];

  logic signed [33:0] r0, r1, r2, cand;
  logic               fl0;
  logic [66:0]        rnd;

  // Reduce into [-180,180) by the one whole-turn offset that lands there,
  // then fold into [-90,90]
  always_comb begin
    r0 = 34'(angle);
    for (int k = -3; k <= 3; k++) begin
      cand = 34'(angle) - 34'(k) * hdu_pkg::Turn;
      if (cand >= -hdu_pkg::Half && cand < hdu_pkg::Half) r0 = cand;
    end
    r1 = r0;
    fl0 = 1'b0;
    if (r0 > hdu_pkg::Quarter) begin
      r1 = hdu_pkg::Half - r0;
      fl0 = 1'b1;
    end else if (r0 < -hdu_pkg::Quarter) begin
      r1 = -hdu_pkg::Half - r0;
      fl0 = 1'b1;
    end
    r2 = (r1 < 0) ? -r1 : r1;
  end

  assign rnd = prod_r + (67'd1 << (hdu_pkg::RadShift - 1));

  // Stage registers ahead of the CORDIC
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= r2;
      neg_r  <= (r1 < 0);
      flip_r <= fl0;
      prod_r <= 67'(mag_r[32:0]) * 67'(hdu_pkg::RadPerDeg);
      neg2_r <= neg_r;
      flip2_r <= flip_r;
      x_r[0] <= hdu_pkg::CordicGain;
      y_r[0] <= '0;
      z_r[0] <= neg2_r ? -34'(rnd >> hdu_pkg::RadShift)
                       : 34'(rnd >> hdu_pkg::RadShift);
      fl_r[0] <= flip2_r;
    end
  end

  // Rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - hdu_pkg::atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + hdu_pkg::atan_q30(i);
        end
        fl_r[i+1] <= fl_r[i];
      end
    end
  end

  assign sin_q30 = y_r[N];
  assign cos_q30 = fl_r[N] ? -x_r[N] : x_r[N];

endmodule

### rtl/haversine_distance_unit.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload
// in_     | in  | point_latitude[23:0] s, point_longitude[24:0] s
// out_    | out | distance_km[22:0]
// cfg_    | in  | index[0], data[24:0]
// One point per cycle while the output is not stalled. Stages in order:
// sine/cosine, products and clamp, square roots, vectoring CORDIC,
// angle clamp and km scaling.
// rst_n is synchronous and clears the valid bits and the reference registers.
// While a result waits at the output the whole pipeline holds; nothing is lost.
module haversine_distance_unit (
  input  logic          clk,
  input  logic          rst_n,
  hdu_point_if.sink     in_ch,
  hdu_dist_if.source    out_ch,
  hdu_cfg_if.sink       cfg_ch
);

  localparam int N  = hdu_pkg::CordicN;
  localparam int SC = 3 + N;          // sincos latency
  localparam int SQ = 31;             // square root steps
  localparam int LAT = SC + 3 + SQ + N + 3;

  logic signed [hdu_pkg::LatW-1:0] ref_lat_r;
  logic signed [hdu_pkg::LonW-1:0] ref_lon_r;
  logic [LAT-1:0] vld_r;
  logic en;

  assign en = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = vld_r[LAT-1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        hdu_pkg::RegRefLat: ref_lat_r <= cfg_ch.data[hdu_pkg::LatW-1:0];
        hdu_pkg::RegRefLon: ref_lon_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  // Four angles
  logic signed [hdu_pkg::HalfW-1:0] a_dlat, a_dlon, a_l1, a_l2;
  assign a_dlat = 28'(in_ch.point_latitude) - 28'(ref_lat_r);
  assign a_dlon = 28'(in_ch.point_longitude) - 28'(ref_lon_r);
  assign a_l1   = 28'(ref_lat_r) <<< 1;
  assign a_l2   = 28'(in_ch.point_latitude) <<< 1;

  logic signed [33:0] su, cu, sv, cv, s1, c1, s2, c2;
  hdu_sincos u_dlat (.clk, .en, .angle(a_dlat), .sin_q30(su), .cos_q30(cu));
  hdu_sincos u_dlon (.clk, .en, .angle(a_dlon), .sin_q30(sv), .cos_q30(cv));
  hdu_sincos u_l1   (.clk, .en, .angle(a_l1),   .sin_q30(s1), .cos_q30(c1));
  hdu_sincos u_l2   (.clk, .en, .angle(a_l2),   .sin_q30(s2), .cos_q30(c2));

  function automatic logic signed [33:0] mq(input logic signed [33:0] a,
                                            input logic signed [33:0] b);
    logic signed [67:0] p;
    begin
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return 34'(p >>> 30);
    end
  endfunction

  // Haversine term
  logic signed [33:0] uu_r, cc_r, vv_r, uu2_r, t_r;
  logic [30:0] a_r;
  logic signed [34:0] asum;
  always_comb begin
    asum = 35'(uu2_r) + 35'(t_r);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      uu_r  <= mq(su, su);
      cc_r  <= mq(c1, c2);
      vv_r  <= mq(sv, sv);
      uu2_r <= uu_r;
      t_r   <= mq(cc_r, vv_r);
      if (asum < 0) a_r <= '0;
      else if (asum > 35'(hdu_pkg::OneQ30)) a_r <= 31'(hdu_pkg::OneQ30);
      else a_r <= 31'(asum);
    end
  end

  // Two square roots, one result bit per stage
  logic [61:0] hn_r [0:SQ];
  logic [61:0] gn_r [0:SQ];
  logic [31:0] hr_r [0:SQ];
  logic [31:0] gr_r [0:SQ];
  always_ff @(posedge clk) begin
    if (en) begin
      hn_r[0] <= {a_r, 31'd0} >> 1;
      gn_r[0] <= {31'(hdu_pkg::OneQ30) - a_r, 31'd0} >> 1;
      hr_r[0] <= '0;
      gr_r[0] <= '0;
    end
  end
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam int B = 2 * (SQ - 1 - k);
    logic [63:0] th, tg;
    assign th = (64'(hr_r[k]) << (SQ - k)) + (64'd1 << B);
    assign tg = (64'(gr_r[k]) << (SQ - k)) + (64'd1 << B);
    always_ff @(posedge clk) begin
      if (en) begin
        if (64'(hn_r[k]) >= th) begin
          hn_r[k+1] <= hn_r[k] - 62'(th);
          hr_r[k+1] <= hr_r[k] | (32'd1 << (SQ - 1 - k));
        end else begin
          hn_r[k+1] <= hn_r[k];
          hr_r[k+1] <= hr_r[k];
        end
        if (64'(gn_r[k]) >= tg) begin
          gn_r[k+1] <= gn_r[k] - 62'(tg);
          gr_r[k+1] <= gr_r[k] | (32'd1 << (SQ - 1 - k));
        end else begin
          gn_r[k+1] <= gn_r[k];
          gr_r[k+1] <= gr_r[k];
        end
      end
    end
  end

  // Vectoring CORDIC
  logic signed [33:0] vx_r [0:N];
  logic signed [33:0] vy_r [0:N];
  logic signed [33:0] vz_r [0:N];
  always_comb begin
    vx_r[0] = 34'(gr_r[SQ]);
    vy_r[0] = 34'(hr_r[SQ]);
    vz_r[0] = '0;
  end
  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy_r[i] > 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + hdu_pkg::atan_q30(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - hdu_pkg::atan_q30(i);
        end
      end
    end
  end

  // Scale to km and saturate
  logic [31:0] z_r;
  logic [hdu_pkg::DistW-1:0] dist_r;
  logic [55:0] dp;
  assign dp = 56'(z_r) * 56'(hdu_pkg::DistScale) + 56'd536870912;
  always_ff @(posedge clk) begin
    if (en) begin
      z_r <= (vz_r[N] < 0) ? '0 : 32'(vz_r[N]);
      dist_r <= ((dp >> 30) > 56'h7fffff) ? '1 : 23'(dp >> 30);
    end
  end
  assign out_ch.distance_km = dist_r;

  logic unused_cos;
  assign unused_cos = cu[0] ^ cv[0] ^ s1[0] ^ s2[0];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.distance_km))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready) else $error("not ready with empty output");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SC+2] |-> a_r <= 31'(hdu_pkg::OneQ30)) else $error("a above one");

endmodule

### bench/tb_haversine_distance_unit.sv
`timescale 1ns / 1ps

// Haversine distance prediction and in-order result checking
class distance_scoreboard;
  localparam longint RadPerDegQ38 = 64'd4797524517;
  localparam longint GainQ30 = 652032874;
  localparam longint OneQ30 = 64'd1073741824;
  localparam longint KmScale = 2 * 6371 * 256;

  longint atan_tbl[32] = '{
    843314856, 497837829, 263043836, 133525158, 67021687, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1, 0, 0};

  logic signed [hdu_pkg::LatW-1:0] home_lat = '0;
  logic signed [hdu_pkg::LonW-1:0] home_lon = '0;
  logic [hdu_pkg::DistW-1:0] pending_km[$];
  int mismatches;

  function void set_home_lat(logic signed [hdu_pkg::LatW-1:0] v);
    home_lat = v;
  endfunction

  function void set_home_lon(logic signed [hdu_pkg::LonW-1:0] v);
    home_lon = v;
  endfunction

  function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Half-angle degrees (17 fraction bits) to Q30 sine and cosine
  function void rotate(longint d, output longint s, output longint c);
    longint turn, half, quarter, r, x, y, z, dx, dy;
    longint unsigned p;
    bit flip;
    turn = 64'sd360 <<< (hdu_pkg::AngleFrac + 1);
    half = turn / 2;
    quarter = turn / 4;
    flip = 0;
    r = d % turn;
    if (r < 0) r += turn;
    if (r >= half) r -= turn;
    if (r > quarter) begin
      r = half - r;
      flip = 1;
    end else if (r < -quarter) begin
      r = -half - r;
      flip = 1;
    end
    p = longint'(r < 0 ? -r : r) * RadPerDegQ38;
    z = longint'((p + (64'd1 << (hdu_pkg::RadShift - 1))) >> hdu_pkg::RadShift);
    if (r < 0) z = -z;
    x = GainQ30;
    y = 0;
    for (int i = 0; i < hdu_pkg::CordicN && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end else begin
        x += dx; y -= dy; z += atan_tbl[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  // Compute the expected distance for one accepted point
  function void note_point(logic signed [hdu_pkg::LatW-1:0] lat,
                           logic signed [hdu_pkg::LonW-1:0] lon);
    longint lat1, lon1, lat2, lon2, su, cu, sv, cv, s1, c1, s2, c2;
    longint a, x, y, z, nx, ny;
    longint unsigned h, g, km;
    lat1 = longint'(home_lat);
    lon1 = longint'(home_lon);
    lat2 = longint'(lat);
    lon2 = longint'(lon);
    rotate(lat2 - lat1, su, cu);
    rotate(lon2 - lon1, sv, cv);
    rotate(lat1 * 2, s1, c1);
    rotate(lat2 * 2, s2, c2);
    a = mul_q30(su, su) + mul_q30(mul_q30(c1, c2), mul_q30(sv, sv));
    if (a < 0) a = 0;
    if (a > OneQ30) a = OneQ30;
    h = int_sqrt(longint'(a) << 30);
    g = int_sqrt(longint'(OneQ30 - a) << 30);
    x = longint'(g);
    y = longint'(h);
    z = 0;
    // Vectoring pass drives y to zero, accumulating the angle
    for (int i = 0; i < hdu_pkg::CordicN && i < 32; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_tbl[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_tbl[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    km = (longint'(z) * KmScale + (64'd1 << 29)) >> 30;
    if (km > (64'd1 << 23) - 1) km = (64'd1 << 23) - 1;
    pending_km = {pending_km, km[hdu_pkg::DistW-1:0]};
  endfunction

  function void check_distance(logic [hdu_pkg::DistW-1:0] got);
    logic [hdu_pkg::DistW-1:0] want;
    if (pending_km.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected distance_km %0d", got);
      return;
    end
    want = pending_km.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("distance_km mismatch: expected %0d, got %0d", want, got);
    end
  endfunction
endclass

module tb_haversine_distance_unit;
  localparam int LatW = hdu_pkg::LatW;
  localparam int LonW = hdu_pkg::LonW;
  localparam int CfgIdxW = hdu_pkg::CfgIdxW;
  localparam int CfgDataW = hdu_pkg::CfgDataW;

  localparam logic signed [LatW-1:0] LatMax = 24'sd5898240;
  localparam logic signed [LonW-1:0] LonMax = 25'sd11796480;

  logic clk = 0;
  logic rst_n = 0;
  bit idle_on = 1;
  int hold_off = 0;

  hdu_point_if pt();
  hdu_dist_if dst();
  hdu_cfg_if cfg();

  distance_scoreboard board = new();

  haversine_distance_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(pt), .out_ch(dst), .cfg_ch(cfg)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    pt.valid = 0;
    pt.point_latitude = '0;
    pt.point_longitude = '0;
    dst.ready = 0;
    cfg.valid = 0;
    cfg.index = hdu_pkg::RegRefLat;
    cfg.data = '0;
  end

  // Offer one point after a random gap (none when idle_on is clear) and hold it until transferred
  task send_point(logic signed [LatW-1:0] lat, logic signed [LonW-1:0] lon);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      @(negedge clk);
      pt.valid <= 0;
    end
    @(negedge clk);
    pt.valid <= 1;
    pt.point_latitude <= lat;
    pt.point_longitude <= lon;
    do @(posedge clk); while (!pt.ready);
    board.note_point(lat, lon);
  endtask

  // Drain all outstanding distances, then write one register
  task write_reg(logic [CfgIdxW-1:0] idx, logic signed [CfgDataW-1:0] val);
    @(negedge clk);
    pt.valid <= 0;
    while (board.pending_km.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == hdu_pkg::RegRefLat) board.set_home_lat(val[LatW-1:0]);
    else board.set_home_lon(val);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task set_home(logic signed [LatW-1:0] lat, logic signed [LonW-1:0] lon);
    write_reg(hdu_pkg::RegRefLat, CfgDataW'(lat));
    write_reg(hdu_pkg::RegRefLon, lon);
  endtask

  function automatic logic signed [LatW-1:0] pick_lat();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return LatW'($urandom);
    if (sel == 1) return board.home_lat + LatW'($urandom_range(0, 2000)) - LatW'(1000);
    return LatW'($urandom_range(0, 2 * int'(LatMax)) - int'(LatMax));
  endfunction

  function automatic logic signed [LonW-1:0] pick_lon();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return LonW'($urandom);
    if (sel == 1) return board.home_lon + LonW'($urandom_range(0, 2000)) - LonW'(1000);
    return LonW'($urandom_range(0, 2 * int'(LonMax)) - int'(LonMax));
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off > 0) begin
        @(negedge clk);
        dst.ready <= 0;
        repeat (hold_off - 1) @(negedge clk);
        hold_off = 0;
      end
      gap = idle_on ? $urandom_range(0, 13) : 0;
      repeat (gap) begin
        @(negedge clk);
        dst.ready <= 0;
      end
      @(negedge clk);
      dst.ready <= 1;
      do @(posedge clk); while (!dst.valid);
      board.check_distance(dst.distance_km);
    end
  end

  initial begin
    #20ms;
    $display("haversine_distance_unit test failed");
    $finish;
  end

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: extremes, antipodes, identical points, out-of-range angles
    send_point('0, '0);
    send_point(LatMax, '0);
    send_point(-LatMax, LonMax);
    send_point('0, LonMax);
    send_point('0, -LonMax);
    send_point(LatMax, LonMax);
    send_point(-LatMax, -LonMax);
    send_point(24'h800000, 25'h1000000);
    send_point(24'sd8388607, 25'sd16777215);
    send_point(24'sd1, 25'sd1);
    send_point(24'sd6000000, 25'sd100);
    set_home(LatMax, LonMax);
    send_point(-LatMax, -LonMax);
    send_point(LatMax, LonMax);
    send_point(LatMax - 24'sd1, LonMax);
    send_point('0, '0);
    set_home(-LatMax, -LonMax);
    send_point(LatMax, LonMax);
    send_point(-LatMax, LonMax);
    set_home(24'h800000, 25'h1000000);
    send_point(24'sd8388607, 25'sd16777215);
    send_point('0, '0);

    // Random phases, each under a new reference point
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_home('0, '0);
      else set_home(LatW'($urandom_range(0, 2 * int'(LatMax)) - int'(LatMax)),
                    LonW'($urandom_range(0, 2 * int'(LonMax)) - int'(LonMax)));
      idle_on = (ph != 2);
      for (int n = 0; n < 325; n++) begin
        if (ph == 3 && n == 20) hold_off = 400;
        send_point(pick_lat(), pick_lon());
      end
    end
    @(negedge clk);
    pt.valid <= 0;

    // Drain, then allow stray results to show up
    waited = 0;
    while (board.pending_km.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (board.pending_km.size() != 0) board.mismatches++;
    if (board.mismatches == 0) begin
      $display("haversine_distance_unit test passed");
    end else begin
      $display("haversine_distance_unit test failed");
    end
    $finish;
  end
endmodule

### haversine_distance_unit.f
rtl/hdu_pkg.sv
rtl/hdu_if.sv
rtl/hdu_sincos.sv
rtl/haversine_distance_unit.sv
bench/tb_haversine_distance_unit.sv
